@@ hdl/aup_pkg.sv @@
// Package for the ASCII unsigned integer parser: item and result types,
// character codes, register indexes and the character classifying functions.
// No dependencies.
package aup_pkg;

	localparam int MAG_W           = 64;
	localparam int RADIX_W         = 6;
	localparam int CONSUMED_W      = 16;
	localparam int IDX_W           = 2;
	localparam int COUNT_W_DEFAULT = 16;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_RADIX     = 2'd0;
	localparam logic [IDX_W-1:0] REG_POS_LIMIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_NEG_LIMIT = 2'd2;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [RADIX_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [RADIX_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd36;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} aup_item_t;

	typedef struct packed {
		logic [MAG_W-1:0]      magnitude;
		logic                  is_positive;
		logic                  range_error;
		logic                  base_error;
		logic [CONSUMED_W-1:0] consumed;
	} aup_result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Digit value 0..35, or DIGIT_NONE for a character that is no digit in any base.
	function automatic logic [RADIX_W-1:0] digit_value(input logic [7:0] c);
		logic [RADIX_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = RADIX_W'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = RADIX_W'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = RADIX_W'(c - CH_UA + 8'd10);
		end
		return d;
	endfunction

endpackage

@@ hdl/aup_if.sv @@
// Valid/ready channel interfaces for the character beats and the result beats.
// Depends on aup_pkg for field widths.
interface aup_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface aup_out_if import aup_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [MAG_W-1:0]      magnitude;
	logic                  is_positive;
	logic                  range_error;
	logic                  base_error;
	logic [CONSUMED_W-1:0] consumed;

	modport source (output valid, output magnitude, output is_positive, output range_error,
		output base_error, output consumed, input ready);
	modport sink (input valid, input magnitude, input is_positive, input range_error,
		input base_error, input consumed, output ready);
endinterface

@@ hdl/aup_in_reg.sv @@
// Input register of the parser: captures one character beat per cycle unless the held beat waits for advance.
// Depends on aup_pkg and aup_in_if.
module aup_in_reg import aup_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	aup_in_if.sink     chars,
	input  logic       advance,
	output logic       valid_s1,
	output aup_item_t  item_s1
);

	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.ch        <= chars.ch;
			item_s1.start_req <= chars.start_req;
		end
	end

endmodule

@@ hdl/aup_step.sv @@
// Parse state, configuration registers and the per-character step logic.
// Depends on aup_pkg.
module aup_step import aup_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_W_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [MAG_W-1:0] wr_data,
	input  logic             fire,
	input  aup_item_t        item,
	output logic             res_valid,
	output aup_result_t      res
);

	localparam logic [2:0] PH_SKIP   = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_HEXPFX = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_IDLE   = 3'd5;

	localparam int PROD_W = MAG_W + RADIX_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int EXT_W  = (COUNT_WIDTH > CONSUMED_W) ? COUNT_WIDTH : CONSUMED_W;

	logic [RADIX_W-1:0]     radix_q;
	logic [MAG_W-1:0]       pos_limit_q;
	logic [MAG_W-1:0]       neg_limit_q;

	logic [2:0]             phase_q;
	logic [MAG_W-1:0]       acc_q;
	logic [RADIX_W-1:0]     base_q;
	logic                   use_neg_q;
	logic                   pos_sign_q;
	logic                   ovf_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic [2:0]             ph_w;
	logic [MAG_W-1:0]       acc_w;
	logic [RADIX_W-1:0]     base_w;
	logic                   use_neg_w;
	logic                   pos_w;
	logic                   ovf_w;
	logic [COUNT_WIDTH-1:0] cnt_w;

	logic                   do_first;
	logic                   do_digit;
	logic [1:0]             inc;
	logic                   emit;
	logic                   berr;
	logic [COUNT_WIDTH-1:0] emit_cnt;
	logic [RADIX_W-1:0]     dval;
	logic [MAG_W-1:0]       lim;
	logic [PROD_W-1:0]      prod;
	logic [SUM_W-1:0]       sum;
	logic [EXT_W-1:0]       cnt_ext;

	function automatic logic [COUNT_WIDTH-1:0] count_add(
		input logic [COUNT_WIDTH-1:0] c,
		input logic [1:0]             n
	);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, c} + (COUNT_WIDTH+1)'(n);
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= BASE_AUTO;
			pos_limit_q <= {MAG_W{1'b1}};
			neg_limit_q <= {1'b1, {(MAG_W-1){1'b0}}};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RADIX:     radix_q     <= wr_data[RADIX_W-1:0];
				REG_POS_LIMIT: pos_limit_q <= wr_data;
				REG_NEG_LIMIT: neg_limit_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ph_w      = phase_q;
		acc_w     = acc_q;
		base_w    = base_q;
		use_neg_w = use_neg_q;
		pos_w     = pos_sign_q;
		ovf_w     = ovf_q;
		cnt_w     = cnt_q;
		do_first  = 1'b0;
		do_digit  = 1'b0;
		inc       = 2'd1;
		emit      = 1'b0;
		berr      = 1'b0;
		emit_cnt  = '0;
		dval      = digit_value(item.ch);
		lim       = '0;
		prod      = '0;
		sum       = '0;

		if (item.start_req) begin
			ph_w      = PH_SKIP;
			acc_w     = '0;
			base_w    = BASE_AUTO;
			use_neg_w = 1'b0;
			pos_w     = 1'b1;
			ovf_w     = 1'b0;
			cnt_w     = '0;
		end

		case (ph_w)
			PH_SKIP: begin
				if (is_space(item.ch)) begin
					cnt_w = count_add(cnt_w, 2'd1);
				end else if (item.ch == CH_MINUS || item.ch == CH_PLUS) begin
					cnt_w = count_add(cnt_w, 2'd1);
					if (item.ch == CH_MINUS) begin
						pos_w     = 1'b0;
						use_neg_w = 1'b1;
					end
					ph_w = PH_FIRST;
				end else begin
					do_first = 1'b1;
				end
			end
			PH_FIRST: do_first = 1'b1;
			PH_ZERO: begin
				if ((item.ch == CH_LX || item.ch == CH_UX) &&
				    (base_w == BASE_AUTO || base_w == BASE_HEX)) begin
					base_w = BASE_HEX;
					ph_w   = PH_HEXPFX;
				end else begin
					if (base_w == BASE_AUTO) begin
						base_w = BASE_OCT;
					end
					do_digit = 1'b1;
				end
			end
			PH_HEXPFX: begin
				// The 'x' of the prefix is counted only once a hex digit follows.
				do_digit = 1'b1;
				inc      = 2'd2;
			end
			PH_DIGITS: do_digit = 1'b1;
			default: ;
		endcase

		if (do_first) begin
			ph_w = PH_FIRST;
			if (radix_q == 6'd1 || radix_q > BASE_MAX) begin
				emit = 1'b1;
				berr = 1'b1;
			end else if (item.ch == CH_ZERO) begin
				base_w = radix_q;
				cnt_w  = count_add(cnt_w, 2'd1);
				ph_w   = PH_ZERO;
			end else begin
				base_w   = (radix_q == BASE_AUTO) ? BASE_DEC : radix_q;
				do_digit = 1'b1;
			end
		end

		if (do_digit) begin
			if (dval < base_w) begin
				// acc * base + digit above the limit is the same test as the
				// divide-then-compare overflow check, done without a divider.
				lim  = use_neg_w ? neg_limit_q : pos_limit_q;
				prod = PROD_W'(acc_w) * PROD_W'(base_w);
				sum  = SUM_W'(prod) + SUM_W'(dval);
				if (sum > SUM_W'(lim)) begin
					acc_w = lim;
					ovf_w = 1'b1;
				end else begin
					acc_w = sum[MAG_W-1:0];
				end
				cnt_w = count_add(cnt_w, inc);
				ph_w  = PH_DIGITS;
			end else begin
				emit     = 1'b1;
				emit_cnt = (ph_w == PH_FIRST) ? '0 : cnt_w;
			end
		end

		if (emit) begin
			ph_w = PH_IDLE;
		end
	end

	assign cnt_ext = EXT_W'(emit_cnt);

	always_comb begin
		res_valid       = emit;
		res.magnitude   = berr ? '0 : acc_w;
		res.is_positive = pos_w;
		res.range_error = ovf_w && !berr;
		res.base_error  = berr;
		res.consumed    = (cnt_ext > EXT_W'({CONSUMED_W{1'b1}})) ? {CONSUMED_W{1'b1}}
			: cnt_ext[CONSUMED_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			acc_q      <= '0;
			base_q     <= BASE_AUTO;
			use_neg_q  <= 1'b0;
			pos_sign_q <= 1'b1;
			ovf_q      <= 1'b0;
			cnt_q      <= '0;
		end else if (fire) begin
			phase_q    <= ph_w;
			acc_q      <= acc_w;
			base_q     <= base_w;
			use_neg_q  <= use_neg_w;
			pos_sign_q <= pos_w;
			ovf_q      <= ovf_w;
			cnt_q      <= cnt_w;
		end
	end

endmodule

@@ hdl/aup_out_reg.sv @@
// Result register of the parser: holds one result beat until it is taken.
// Depends on aup_pkg and aup_out_if.
module aup_out_reg import aup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  aup_result_t res,
	output logic        free,
	aup_out_if.source   results
);

	aup_result_t res_q;

	assign free = !results.valid || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (load) begin
			results.valid <= 1'b1;
		end else if (results.ready) begin
			results.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign results.magnitude   = res_q.magnitude;
	assign results.is_positive = res_q.is_positive;
	assign results.range_error = res_q.range_error;
	assign results.base_error  = res_q.base_error;
	assign results.consumed    = res_q.consumed;

endmodule

@@ hdl/ascii_unsigned_integer_parser_unit.sv @@
// Streaming ASCII to unsigned integer parser, one character beat per cycle
// while the result register is free. The character ending the number is held
// in the input register, its result beat then in the result register. The rate is
// set by the accumulator loop, a combinational 64x6 multiply-add and limit compare.
// Reset (arst_n low) clears the parse state and loads the register defaults.
module ascii_unsigned_integer_parser_unit import aup_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_W_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	aup_in_if.sink           chars,
	aup_out_if.source        results,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [MAG_W-1:0] wr_data
);

	logic        valid_s1;
	aup_item_t   item_s1;
	logic        free;
	logic        fire;
	logic        res_valid;
	aup_result_t res;

	assign fire = valid_s1 && free;

	aup_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.advance  (free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	aup_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	aup_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && res_valid),
		.res     (res),
		.free    (free),
		.results (results)
	);

endmodule

@@ hdl/aup_checker.sv @@
// Port-level checks for the parser and the bind that attaches them.
// Depends on aup_pkg and ascii_unsigned_integer_parser_unit.
module aup_checker import aup_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [MAG_W-1:0]      magnitude,
	input logic                  range_error,
	input logic                  base_error,
	input logic [CONSUMED_W-1:0] consumed
);

	// A pending result beat is never withdrawn.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A base error reports no magnitude, no range error and no consumed count.
	a_berr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && base_error |-> magnitude == '0 && !range_error && consumed == '0)
		else $error("base error beat carries a value");

	// No result beat while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result beat during reset");

	// A fresh result beat stems from a character beat taken at the input.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat without a character beat");

endmodule

bind ascii_unsigned_integer_parser_unit aup_checker u_aup_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (chars.valid),
	.in_ready    (chars.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.magnitude   (results.magnitude),
	.range_error (results.range_error),
	.base_error  (results.base_error),
	.consumed    (results.consumed)
);
